[hdl/audio_sample_counter_regs_core_macros.svh]
// Assertion macros for the audio sample counter register block.
`ifndef AUDIO_SAMPLE_COUNTER_REGS_CORE_MACROS_SVH
`define AUDIO_SAMPLE_COUNTER_REGS_CORE_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an implication holds in the cycle after its antecedent, outside reset.
`define ASC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/asc_pkg.sv]
package asc_pkg;

  localparam int unsigned CpuClkW = 30;
  localparam int unsigned RateW   = 18;
  localparam int unsigned AccW    = 35;
  localparam int unsigned DivCntW = 6;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [3:0] OFS_CONTROL = 4'h0;
  localparam logic [3:0] OFS_VOLUME  = 4'h4;
  localparam logic [3:0] OFS_COUNTER = 4'h8;
  localparam logic [3:0] OFS_TARGET  = 4'hC;

  localparam int unsigned CTL_PLAY     = 0;
  localparam int unsigned CTL_FAST     = 1;
  localparam int unsigned CTL_MASK     = 2;
  localparam int unsigned CTL_STATUS   = 3;
  localparam int unsigned CTL_DISABLE  = 4;
  localparam int unsigned CTL_CNTRESET = 5;
  localparam int unsigned CTL_DMASLOW  = 6;

  localparam logic [1:0] CFG_CPU_CLOCK = 2'd0;
  localparam logic [1:0] CFG_RATE_FAST = 2'd1;
  localparam logic [1:0] CFG_RATE_SLOW = 2'd2;

  typedef struct packed {
    logic reg_write;
    logic mul_start;
    logic div_start;
    logic tick_commit;
    logic out_load;
  } asc_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } asc_status_t;

endpackage

[hdl/audio_sample_counter_regs_core.sv]
// Audio register block with sample counter. Each transaction returns one
// result. Reads, writes and ticks while stopped pass through a write step;
// a tick while playing runs a multiply and then the bit-serial restoring
// divider that resolves one quotient bit of the 35-bit accumulator per cycle.
module audio_sample_counter_regs_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_address,
  input  logic        in_size_is_word,
  input  logic [31:0] in_write_data,
  input  logic [15:0] in_tick_cycles,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_irq_line
);

  asc_pkg::asc_cmd_t    cmd;
  asc_pkg::asc_status_t stat;
  logic                 playing;

  asc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .playing,
    .out_valid, .out_ready, .cmd, .stat
  );

  asc_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_fire(in_valid && in_ready), .in_func, .in_address, .in_size_is_word,
    .in_write_data, .in_tick_cycles, .cmd, .stat, .playing,
    .out_read_data, .out_irq_line
  );

endmodule

[hdl/asc_ctrl.sv]
module asc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic               playing,
  output logic               out_valid,
  input  logic               out_ready,
  output asc_pkg::asc_cmd_t  cmd,
  input  asc_pkg::asc_status_t stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_MUL, S_DIV, S_COMMIT, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == asc_pkg::FUNC_TICK && playing) begin
            cmd.mul_start = 1'b1;
            state_nxt     = S_MUL;
          end else begin
            state_nxt     = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        cmd.reg_write = 1'b1;
        state_nxt     = S_OUT;
      end
      S_MUL: begin
        if (stat.mul_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.tick_commit = 1'b1;
        state_nxt       = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/asc_datapath.sv]
module asc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [29:0]         cfg_wdata,
  input  logic                in_fire,
  input  logic [1:0]          in_func,
  input  logic [3:0]          in_address,
  input  logic                in_size_is_word,
  input  logic [31:0]         in_write_data,
  input  logic [15:0]         in_tick_cycles,
  input  asc_pkg::asc_cmd_t   cmd,
  output asc_pkg::asc_status_t stat,
  output logic                playing,
  output logic [31:0]         out_read_data,
  output logic                out_irq_line
);

  logic [29:0] cpu_clk_r;
  logic [17:0] rate_fast_r, rate_slow_r;
  logic        play_r, fast_r, mask_r, status_r, disable_r, dmaslow_r;
  logic [15:0] volume_r;
  logic [31:0] count_r, target_r;
  logic [29:0] rem_r;

  logic [1:0]  func_r;
  logic [3:0]  addr_r;
  logic        word_r;
  logic [31:0] wdata_r;

  logic [33:0] prod_r;
  logic        mul_done_r;
  logic [34:0] quo_r;
  logic [30:0] pr_r;
  logic [34:0] dividend_r;
  logic [29:0] divisor_r;
  logic [5:0]  dcnt_r;
  logic        div_busy_r;
  logic        div_done_r;

  logic [31:0] read_mux;
  logic [31:0] rdata_r;
  logic        irq_r;
  logic [30:0] pr_shift;
  logic [30:0] pr_sub;
  logic [31:0] new_count;
  logic        passed;
  logic [17:0] rate_sel;

  assign playing       = play_r;
  assign stat.mul_done = mul_done_r;
  assign stat.div_done = div_done_r;
  assign out_read_data = rdata_r;
  assign out_irq_line  = irq_r;
  assign rate_sel      = fast_r ? rate_fast_r : rate_slow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_clk_r   <= 30'd729000000;
      rate_fast_r <= 18'd48000;
      rate_slow_r <= 18'd32000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asc_pkg::CFG_CPU_CLOCK: cpu_clk_r   <= cfg_wdata;
        asc_pkg::CFG_RATE_FAST: rate_fast_r <= cfg_wdata[17:0];
        asc_pkg::CFG_RATE_SLOW: rate_slow_r <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= in_func;
      addr_r   <= in_address;
      word_r   <= in_size_is_word;
      wdata_r  <= in_write_data;
    end
  end

  always_comb begin
    read_mux = '0;
    unique case (addr_r)
      asc_pkg::OFS_CONTROL: begin
        read_mux[asc_pkg::CTL_PLAY]    = play_r;
        read_mux[asc_pkg::CTL_FAST]    = fast_r;
        read_mux[asc_pkg::CTL_MASK]    = mask_r;
        read_mux[asc_pkg::CTL_STATUS]  = status_r;
        read_mux[asc_pkg::CTL_DISABLE] = disable_r;
        read_mux[asc_pkg::CTL_DMASLOW] = dmaslow_r;
      end
      asc_pkg::OFS_VOLUME:  read_mux = {16'd0, volume_r};
      asc_pkg::OFS_COUNTER: read_mux = count_r;
      asc_pkg::OFS_TARGET:  read_mux = target_r;
      default:              read_mux = '0;
    endcase
  end

  // Restoring divider step: shift in the next dividend bit
  assign pr_shift = {pr_r[29:0], dividend_r[34]};
  assign pr_sub   = pr_shift - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_done_r <= 1'b0;
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      mul_done_r <= cmd.mul_start;
      div_done_r <= 1'b0;
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && dcnt_r == 6'd0) begin
        div_busy_r <= 1'b0;
        div_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod_r <= {18'd0, in_tick_cycles} * {16'd0, rate_sel};
    end
    if (cmd.div_start) begin
      dividend_r <= {1'b0, prod_r} + {5'd0, rem_r};
      divisor_r  <= (cpu_clk_r == '0) ? 30'd1 : cpu_clk_r;
      pr_r       <= '0;
      quo_r      <= '0;
      dcnt_r     <= 6'(asc_pkg::AccW - 1);
    end else if (div_busy_r) begin
      dividend_r <= {dividend_r[33:0], 1'b0};
      dcnt_r     <= dcnt_r - 6'd1;
      if (!pr_sub[30]) begin
        pr_r  <= pr_sub;
        quo_r <= {quo_r[33:0], 1'b1};
      end else begin
        pr_r  <= pr_shift;
        quo_r <= {quo_r[33:0], 1'b0};
      end
    end
  end

  assign new_count = count_r + quo_r[31:0];
  always_comb begin
    if (count_r <= new_count)
      passed = (target_r > count_r) && (target_r <= new_count);
    else
      passed = (target_r > count_r) || (target_r <= new_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r    <= 1'b0;
      fast_r    <= 1'b0;
      mask_r    <= 1'b0;
      status_r  <= 1'b0;
      disable_r <= 1'b0;
      dmaslow_r <= 1'b0;
      volume_r  <= '0;
      count_r   <= '0;
      target_r  <= '0;
      rem_r     <= '0;
    end else if (cmd.reg_write && func_r == asc_pkg::FUNC_WRITE && word_r) begin
      unique case (addr_r)
        asc_pkg::OFS_CONTROL: begin
          if (wdata_r[asc_pkg::CTL_STATUS]) status_r <= 1'b0;
          if (wdata_r[asc_pkg::CTL_CNTRESET] ||
              wdata_r[asc_pkg::CTL_FAST] != fast_r) rem_r <= '0;
          if (wdata_r[asc_pkg::CTL_CNTRESET]) count_r <= '0;
          play_r    <= wdata_r[asc_pkg::CTL_PLAY];
          fast_r    <= wdata_r[asc_pkg::CTL_FAST];
          mask_r    <= wdata_r[asc_pkg::CTL_MASK];
          disable_r <= wdata_r[asc_pkg::CTL_DISABLE];
          dmaslow_r <= wdata_r[asc_pkg::CTL_DMASLOW];
        end
        asc_pkg::OFS_VOLUME:  volume_r <= wdata_r[15:0];
        asc_pkg::OFS_COUNTER: begin
          count_r <= wdata_r;
          rem_r   <= '0;
        end
        asc_pkg::OFS_TARGET:  target_r <= wdata_r;
        default: ;
      endcase
    end else if (cmd.tick_commit) begin
      rem_r <= pr_r[29:0];
      if (quo_r[31:0] != '0) begin
        count_r <= new_count;
        if (!disable_r && passed) status_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rdata_r <= (func_r == asc_pkg::FUNC_READ && word_r) ? read_mux : '0;
      irq_r   <= status_r && mask_r;
    end
  end

endmodule

[hdl/asc_checker.sv]
`include "audio_sample_counter_regs_core_macros.svh"

module asc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_read_data
);

  `ASC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "accepted twice")
  `ASC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_data), "result dropped")
  `ASC_ASSERT_NEXT(a_no_early_out, clk, rst_n, in_valid && in_ready, !in_ready && !(out_valid && $rose(out_valid) && in_ready), "result too early")

endmodule

bind audio_sample_counter_regs_core asc_checker u_asc_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_read_data
);

[sim/tb_audio_sample_counter_regs_core.sv]
module tb_audio_sample_counter_regs_core;
  import asc_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  address;
    logic        size_is_word;
    logic [31:0] write_data;
    logic [15:0] tick_cycles;
  } access_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [29:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [3:0]  in_address;
  logic        in_size_is_word;
  logic [31:0] in_write_data;
  logic [15:0] in_tick_cycles;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_data;
  logic        out_irq_line;

  audio_sample_counter_regs_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_address     (in_address),
    .in_size_is_word(in_size_is_word),
    .in_write_data  (in_write_data),
    .in_tick_cycles (in_tick_cycles),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_irq_line   (out_irq_line)
  );

  logic [29:0] cpu_clock_hz;
  logic [17:0] rate_fast_hz;
  logic [17:0] rate_slow_hz;
  logic        playing;
  logic        stream_fast;
  logic        irq_mask;
  logic        irq_status;
  logic        irq_disable;
  logic        dma_slow;
  logic [15:0] volume;
  logic [31:0] sample_count;
  logic [31:0] irq_target;
  logic [63:0] cycle_remainder;

  reply_t      pending_replies[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          idle_enable;
  bit          hold_off_req;
  int unsigned hold_off_len;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] reg_value(logic [3:0] ofs);
    logic [31:0] v;
    v = '0;
    case (ofs)
      OFS_CONTROL: begin
        v[CTL_PLAY]    = playing;
        v[CTL_FAST]    = stream_fast;
        v[CTL_MASK]    = irq_mask;
        v[CTL_STATUS]  = irq_status;
        v[CTL_DISABLE] = irq_disable;
        v[CTL_DMASLOW] = dma_slow;
      end
      OFS_VOLUME:  v = {16'h0, volume};
      OFS_COUNTER: v = sample_count;
      OFS_TARGET:  v = irq_target;
      default:     v = '0;
    endcase
    return v;
  endfunction

  function automatic bit crossed_target(logic [31:0] from, logic [31:0] to, logic [31:0] tgt);
    if (from <= to) return (tgt > from) && (tgt <= to);
    return (tgt > from) || (tgt <= to);
  endfunction

  function automatic void apply_register_write(logic [3:0] ofs, logic [31:0] v);
    case (ofs)
      OFS_CONTROL: begin
        if (v[CTL_STATUS]) irq_status = 1'b0;
        if (v[CTL_CNTRESET]) begin
          sample_count    = '0;
          cycle_remainder = '0;
        end
        playing = v[CTL_PLAY];
        if (v[CTL_FAST] != stream_fast) cycle_remainder = '0;
        stream_fast = v[CTL_FAST];
        irq_mask    = v[CTL_MASK];
        irq_disable = v[CTL_DISABLE];
        dma_slow    = v[CTL_DMASLOW];
      end
      OFS_VOLUME: volume = v[15:0];
      OFS_COUNTER: begin
        sample_count    = v;
        cycle_remainder = '0;
      end
      OFS_TARGET: irq_target = v;
      default: ;
    endcase
  endfunction

  function automatic void advance_counter(logic [15:0] cycles);
    logic [63:0] divisor;
    logic [63:0] acc;
    logic [63:0] quotient;
    logic [31:0] samples;
    logic [31:0] from;
    if (!playing) return;
    divisor = (cpu_clock_hz == 0) ? 64'd1 : {34'h0, cpu_clock_hz};
    acc = cycle_remainder + 64'(cycles) * 64'(stream_fast ? rate_fast_hz : rate_slow_hz);
    quotient        = acc / divisor;
    samples         = quotient[31:0];
    cycle_remainder = acc % divisor;
    if (samples == 0) return;
    from         = sample_count;
    sample_count = from + samples;
    if (!irq_disable && crossed_target(from, sample_count, irq_target)) irq_status = 1'b1;
  endfunction

  function automatic reply_t predict_reply(access_t a);
    reply_t r;
    r.read_data = '0;
    case (a.func)
      FUNC_READ:  if (a.size_is_word) r.read_data = reg_value(a.address);
      FUNC_WRITE: if (a.size_is_word) apply_register_write(a.address, a.write_data);
      FUNC_TICK:  advance_counter(a.tick_cycles);
      default: ;
    endcase
    r.irq_line = irq_status & irq_mask;
    return r;
  endfunction

  task automatic reset_model();
    cpu_clock_hz    = 30'd729000000;
    rate_fast_hz    = 18'd48000;
    rate_slow_hz    = 18'd32000;
    playing         = 1'b0;
    stream_fast     = 1'b0;
    irq_mask        = 1'b0;
    irq_status      = 1'b0;
    irq_disable     = 1'b0;
    dma_slow        = 1'b0;
    volume          = '0;
    sample_count    = '0;
    irq_target      = '0;
    cycle_remainder = '0;
  endtask

  task automatic send_access(access_t a);
    int unsigned gap;
    if (idle_enable && ($urandom_range(0, 3) == 0)) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= a.func;
    in_address      <= a.address;
    in_size_is_word <= a.size_is_word;
    in_write_data   <= a.write_data;
    in_tick_cycles  <= a.tick_cycles;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(predict_reply(a));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_config(logic [1:0] idx, logic [29:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_CPU_CLOCK: cpu_clock_hz = value;
      CFG_RATE_FAST: rate_fast_hz = value[17:0];
      CFG_RATE_SLOW: rate_slow_hz = value[17:0];
      default: ;
    endcase
  endtask

  function automatic access_t make_access(logic [1:0] f, logic [3:0] ofs, logic [31:0] d,
                                          logic [15:0] cyc, logic word = 1'b1);
    access_t a;
    a.func         = f;
    a.address      = ofs;
    a.size_is_word = word;
    a.write_data   = d;
    a.tick_cycles  = cyc;
    return a;
  endfunction

  function automatic access_t random_access();
    access_t a;
    logic [3:0] ofs_pick[4];
    int unsigned pick;
    ofs_pick = '{OFS_CONTROL, OFS_VOLUME, OFS_COUNTER, OFS_TARGET};
    a.write_data   = $urandom();
    a.tick_cycles  = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4000));
    a.size_is_word = ($urandom_range(0, 9) != 0);
    a.address      = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : ofs_pick[$urandom_range(0, 3)];
    pick = $urandom_range(0, 19);
    if (pick < 8) a.func = FUNC_TICK;
    else if (pick < 13) a.func = FUNC_READ;
    else if (pick < 19) a.func = FUNC_WRITE;
    else a.func = FUNC_SPARE;
    if (a.func == FUNC_WRITE && a.address == OFS_CONTROL && $urandom_range(0, 2) != 0) begin
      a.write_data[CTL_PLAY]     = 1'b1;
      a.write_data[CTL_CNTRESET] = ($urandom_range(0, 5) == 0);
    end
    if (a.func == FUNC_WRITE && a.address == OFS_TARGET && $urandom_range(0, 1) == 0)
      a.write_data = sample_count + $urandom_range(0, 200);
    return a;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_req) begin
      out_ready <= 1'b0;
      if (hold_off_len == 0) hold_off_req <= 1'b0;
      else hold_off_len <= hold_off_len - 1;
    end else if (idle_cycles != 0) begin
      out_ready   <= 1'b0;
      idle_cycles <= idle_cycles - 1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      out_ready   <= 1'b0;
      idle_cycles <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result read_data=%h irq_line=%b", out_read_data, out_irq_line);
        error_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_read_data !== exp_r.read_data) begin
          $error("read_data expected %h actual %h", exp_r.read_data, out_read_data);
          error_count++;
        end
        if (out_irq_line !== exp_r.irq_line) begin
          $error("irq_line expected %b actual %b", exp_r.irq_line, out_irq_line);
          error_count++;
        end
      end
    end
  end

  int unsigned stall_count;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count == WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic test_registers();
    send_access(make_access(FUNC_READ, OFS_CONTROL, '0, '0));
    send_access(make_access(FUNC_WRITE, OFS_VOLUME, 32'hFFFF_FFFF, '0));
    send_access(make_access(FUNC_READ, OFS_VOLUME, '0, '0));
    send_access(make_access(FUNC_WRITE, OFS_TARGET, 32'hFFFF_FFFF, 16'hFFFF));
    send_access(make_access(FUNC_READ, OFS_TARGET, '0, '0));
    send_access(make_access(FUNC_WRITE, OFS_COUNTER, 32'hFFFF_FFF0, '0));
    send_access(make_access(FUNC_READ, OFS_COUNTER, '0, '0));
    send_access(make_access(FUNC_WRITE, OFS_VOLUME, 32'h1234_5678, '0, 1'b0));
    send_access(make_access(FUNC_READ, OFS_VOLUME, '0, '0, 1'b0));
    send_access(make_access(FUNC_WRITE, 4'h3, 32'hFFFF_FFFF, '0));
    send_access(make_access(FUNC_READ, 4'hF, '0, '0));
    send_access(make_access(FUNC_SPARE, OFS_CONTROL, 32'hFFFF_FFFF, 16'hFFFF));
    send_access(make_access(FUNC_TICK, OFS_CONTROL, '0, 16'hFFFF));
    send_access(make_access(FUNC_WRITE, OFS_CONTROL, 32'hFFFF_FFFF, '0));
    send_access(make_access(FUNC_READ, OFS_CONTROL, '0, '0));
  endtask

  task automatic test_counter_wrap();
    send_access(make_access(FUNC_WRITE, OFS_CONTROL, 32'h0000_0047, '0));
    send_access(make_access(FUNC_WRITE, OFS_COUNTER, 32'hFFFF_FFF0, '0));
    send_access(make_access(FUNC_WRITE, OFS_TARGET, 32'h0000_0002, '0));
    send_access(make_access(FUNC_TICK, '0, '0, 16'hFFFF));
    send_access(make_access(FUNC_READ, OFS_CONTROL, '0, '0));
    send_access(make_access(FUNC_WRITE, OFS_CONTROL, 32'h0000_0015, '0));
    send_access(make_access(FUNC_TICK, '0, '0, 16'hFFFF));
    send_access(make_access(FUNC_WRITE, OFS_CONTROL, 32'h0000_000D, '0));
    send_access(make_access(FUNC_TICK, '0, '0, 16'd0));
    send_access(make_access(FUNC_READ, OFS_COUNTER, '0, '0));
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_access(random_access());
  endtask

  task automatic test_backpressure();
    hold_off_len <= 300;
    hold_off_req <= 1'b1;
    run_random(12);
    wait_drained();
  endtask

  task automatic test_config_sweep();
    logic [29:0] clocks[4];
    logic [17:0] rates[3];
    clocks = '{30'd1, 30'd0, 30'h3FFF_FFFF, 30'd729000000};
    rates  = '{18'd1, 18'h3FFFF, 18'd192000};
    foreach (clocks[i]) begin
      wait_drained();
      write_config(CFG_CPU_CLOCK, clocks[i]);
      write_config(CFG_RATE_FAST, rates[$urandom_range(0, 2)]);
      write_config(CFG_RATE_SLOW, rates[$urandom_range(0, 2)]);
      run_random(40);
    end
    wait_drained();
    write_config(CFG_CPU_CLOCK, 30'd100000);
    write_config(CFG_RATE_FAST, 18'd48000);
    write_config(CFG_RATE_SLOW, 18'd32000);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_func         = '0;
    in_address      = '0;
    in_size_is_word = 1'b0;
    in_write_data   = '0;
    in_tick_cycles  = '0;
    error_count     = 0;
    idle_cycles     = 0;
    idle_enable     = 1'b0;
    hold_off_req    = 1'b0;
    hold_off_len    = 0;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_registers();
    test_counter_wrap();
    idle_enable = 1'b1;
    test_config_sweep();
    test_backpressure();
    run_random(240);
    wait_drained();
    idle_enable = 1'b0;
    run_random(60);
    wait_drained();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/asc_pkg.sv
hdl/asc_ctrl.sv
hdl/asc_datapath.sv
hdl/audio_sample_counter_regs_core.sv
hdl/asc_checker.sv
sim/tb_audio_sample_counter_regs_core.sv
